[hdl/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types, register indexes and rounding helpers for the cubic
// trajectory point evaluator.
// ----------------------------------------------------------------------------
package ctp_pkg;

   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STAGES = 32;
   localparam int BACK_STAGES = 5;
   localparam int CTP_LATENCY = DIV_STAGES + BACK_STAGES;

   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TIME       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_POSITION   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VELOCITY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_VELOCITY   = 3'd5;

   localparam logic [31:0] Q31_ONE = 32'h8000_0000;

   typedef enum logic [1:0] {
      CLS_START = 2'd0,
      CLS_END   = 2'd1,
      CLS_CURVE = 2'd2
   } cls_type;

   typedef struct packed {
      logic signed [31:0] start_time;
      logic signed [31:0] end_time;
      logic signed [31:0] start_position;
      logic signed [31:0] end_position;
      logic signed [31:0] start_velocity;
      logic signed [31:0] end_velocity;
   } cfg_type;

   typedef struct packed {
      cls_type     cls;
      logic [31:0] elapsed;
   } item_type;

   // round half up, then drop 31 fraction bits
   function automatic logic [34:0] urnd31(input logic [65:0] x);
      logic [65:0] y;
      y = x + 66'h0_4000_0000;
      return y[65:31];
   endfunction

endpackage

[hdl/ctp_front.sv]
// ----------------------------------------------------------------------------
// ctp_front
// Configuration registers and classification of each sample time into
// before-start, after-end or on-curve, with the elapsed time.
// ----------------------------------------------------------------------------
module ctp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ctp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   input  logic signed [31:0]            req_sample_time,
   output ctp_pkg::item_type             item,
   output ctp_pkg::cfg_type              cfg
);
   import ctp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic signed [32:0] elapsed;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_TIME:     cfg_in.start_time     = csr_data;
            CSR_END_TIME:       cfg_in.end_time       = csr_data;
            CSR_START_POSITION: cfg_in.start_position = csr_data;
            CSR_END_POSITION:   cfg_in.end_position   = csr_data;
            CSR_START_VELOCITY: cfg_in.start_velocity = csr_data;
            CSR_END_VELOCITY:   cfg_in.end_velocity   = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_time     <= 32'sd0;
         cfg_ff.end_time       <= 32'sd65536;
         cfg_ff.start_position <= 32'sd0;
         cfg_ff.end_position   <= 32'sd0;
         cfg_ff.start_velocity <= 32'sd0;
         cfg_ff.end_velocity   <= 32'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      elapsed = 33'(req_sample_time) - 33'(cfg_ff.start_time);
      item.elapsed = elapsed[31:0];
      if (req_sample_time < cfg_ff.start_time) begin
         item.cls = CLS_START;
      end else if (req_sample_time > cfg_ff.end_time ||
                   cfg_ff.end_time <= cfg_ff.start_time) begin
         item.cls = CLS_END;
      end else begin
         item.cls = CLS_CURVE;
      end
   end

endmodule

[hdl/ctp_queue.sv]
// ----------------------------------------------------------------------------
// ctp_queue
// Two-entry item queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module ctp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctp_pkg::item_type push_item,
   output logic              full,
   output logic              pop_valid,
   output ctp_pkg::item_type pop_item
);
   import ctp_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/ctp_div.sv]
// ----------------------------------------------------------------------------
// ctp_div
// Pipelined restoring divider: one quotient bit per stage gives the
// normalized time s = floor(elapsed * 2^31 / duration).
// ----------------------------------------------------------------------------
module ctp_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ctp_pkg::item_type   in_item,
   input  logic [31:0]         duration,
   output logic                out_valid,
   output ctp_pkg::cls_type    out_cls,
   output logic [31:0]         out_q
);
   import ctp_pkg::*;

   logic [31:0] r_ff   [DIV_STAGES];
   logic [31:0] r_in   [DIV_STAGES];
   logic [31:0] q_ff   [DIV_STAGES];
   logic [31:0] q_in   [DIV_STAGES];
   cls_type     cls_ff [DIV_STAGES];
   logic        v_ff   [DIV_STAGES];
   logic [32:0] rem    [DIV_STAGES];
   logic [32:0] diff   [DIV_STAGES];
   logic        ge     [DIV_STAGES];

   always_comb begin
      rem[0] = {1'b0, in_item.elapsed};
      for (int k = 1; k < DIV_STAGES; k++) begin
         rem[k] = {r_ff[k-1], 1'b0};
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         diff[k] = rem[k] - {1'b0, duration};
         ge[k]   = (rem[k] >= {1'b0, duration});
         r_in[k] = ge[k] ? diff[k][31:0] : rem[k][31:0];
      end
      q_in[0] = {31'd0, ge[0]};
      for (int k = 1; k < DIV_STAGES; k++) begin
         q_in[k] = {q_ff[k-1][30:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STAGES; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff[0] <= in_item.cls;
      for (int k = 1; k < DIV_STAGES; k++) begin
         cls_ff[k] <= cls_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         r_ff[k] <= r_in[k];
         q_ff[k] <= q_in[k];
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_cls   = cls_ff[DIV_STAGES-1];
   assign out_q     = q_ff[DIV_STAGES-1];

endmodule

[hdl/ctp_back.sv]
// ----------------------------------------------------------------------------
// ctp_back
// Hermite basis multiplier chain, velocity scaling, final sum with
// saturation and selection of the boundary cases.
// ----------------------------------------------------------------------------
module ctp_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ctp_pkg::cls_type in_cls,
   input  logic [31:0]      in_s,
   input  ctp_pkg::cfg_type cfg,
   output logic             rsp_valid,
   output logic [31:0]      rsp_position,
   output logic             rsp_saturated
);
   import ctp_pkg::*;

   localparam logic signed [65:0] HALF31 = 66'sd1 <<< 30;
   localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] POS_MAX = 64'sd2147483647;
   localparam logic signed [63:0] POS_MIN = -64'sd2147483648;

   logic    v_ff [BACK_STAGES];
   cls_type cls_ff [BACK_STAGES-1];

   // stage 1
   logic [31:0] u;
   logic [31:0] s1_ff, u1_ff;
   logic [63:0] pss_ff, psu_ff;
   // stage 2
   logic [34:0] s2_w, su_w;
   logic [32:0] w;
   logic [64:0] ph_ff;
   logic [63:0] pg0_ff, pg1_ff;
   // stage 3
   logic [34:0] h_w, g0_w, g1_w;
   logic [32:0] dur_w;
   logic signed [32:0] dpos;
   logic [63:0] pa_ff, pb_ff;
   logic signed [65:0] pd_ff;
   // stage 4
   logic [34:0] a_w, b_w;
   logic signed [65:0] pd_rnd;
   logic signed [63:0] pva_ff, pvb_ff;
   logic signed [34:0] pd31_ff;
   // stage 5
   logic signed [63:0] va_rnd, vb_rnd, sum;
   logic [31:0] pos_in, pos_ff;
   logic        sat_in, sat_ff;

   always_comb begin
      u      = Q31_ONE - in_s;
      s2_w   = urnd31(66'(pss_ff));
      su_w   = urnd31(66'(psu_ff));
      w      = 33'h1_8000_0000 - {s1_ff, 1'b0};
      h_w    = urnd31(66'(ph_ff));
      g0_w   = urnd31(66'(pg0_ff));
      g1_w   = urnd31(66'(pg1_ff));
      dur_w  = 33'(cfg.end_time) - 33'(cfg.start_time);
      dpos   = 33'(cfg.end_position) - 33'(cfg.start_position);
      a_w    = urnd31(66'(pa_ff));
      b_w    = urnd31(66'(pb_ff));
      pd_rnd = (pd_ff + HALF31) >>> 31;
      va_rnd = (pva_ff + HALF_F) >>> FRAC_BITS;
      vb_rnd = (pvb_ff + HALF_F) >>> FRAC_BITS;
      sum    = 64'(cfg.start_position) + 64'(pd31_ff) + va_rnd - vb_rnd;
   end

   always_comb begin
      sat_in = 1'b0;
      case (cls_ff[BACK_STAGES-2])
         CLS_START: pos_in = cfg.start_position;
         CLS_END:   pos_in = cfg.end_position;
         CLS_CURVE: begin
            if (sum > POS_MAX) begin
               pos_in = 32'h7FFF_FFFF;
               sat_in = 1'b1;
            end else if (sum < POS_MIN) begin
               pos_in = 32'h8000_0000;
               sat_in = 1'b1;
            end else begin
               pos_in = sum[31:0];
            end
         end
         default:   pos_in = cfg.end_position;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BACK_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < BACK_STAGES; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff[0] <= in_cls;
      for (int k = 1; k < BACK_STAGES - 1; k++) begin
         cls_ff[k] <= cls_ff[k-1];
      end
      s1_ff   <= in_s;
      u1_ff   <= u;
      pss_ff  <= 64'(in_s) * 64'(in_s);
      psu_ff  <= 64'(in_s) * 64'(u);
      ph_ff   <= 65'(s2_w[31:0]) * 65'(w);
      pg0_ff  <= 64'(su_w[31:0]) * 64'(u1_ff);
      pg1_ff  <= 64'(s2_w[31:0]) * 64'(u1_ff);
      pa_ff   <= 64'(g0_w[31:0]) * 64'(dur_w[31:0]);
      pb_ff   <= 64'(g1_w[31:0]) * 64'(dur_w[31:0]);
      pd_ff   <= 66'(dpos) * 66'($signed({1'b0, h_w[31:0]}));
      pva_ff  <= 64'(cfg.start_velocity) * 64'($signed({1'b0, a_w[31:0]}));
      pvb_ff  <= 64'(cfg.end_velocity) * 64'($signed({1'b0, b_w[31:0]}));
      pd31_ff <= pd_rnd[34:0];
      pos_ff  <= pos_in;
      sat_ff  <= sat_in;
   end

   assign rsp_valid     = v_ff[BACK_STAGES-1];
   assign rsp_position  = pos_ff;
   assign rsp_saturated = sat_ff;

endmodule

[hdl/cubic_trajectory_point.sv]
// ----------------------------------------------------------------------------
// cubic_trajectory_point
// Evaluates one cubic Hermite trajectory segment at each sample time.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  request   start, busy, req_sample_time           start && !busy
//  response  rsp_valid, rsp_position, rsp_saturated one-cycle strobe
//  csr       csr_valid, csr_ready, csr_index/data   csr_valid && csr_ready
//
//  One item per cycle sustained; each result passes from its item through the
//  two-entry queue, the 32-stage divider pipeline and five multiply/sum stages.
//  Synchronous reset loads the register reset values and empties the queue
//  and both pipelines. The response side cannot stall; busy rises only when
//  the two-entry queue is full.
// ----------------------------------------------------------------------------
module cubic_trajectory_point #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_sample_time,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_position,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ctp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import ctp_pkg::*;

   item_type    front_item;
   cfg_type     cfg;
   logic        q_full;
   logic        q_valid;
   item_type    q_item;
   logic        div_valid;
   cls_type     div_cls;
   logic [31:0] div_q;
   logic [32:0] duration;
   logic [31:0] position;

   assign busy     = q_full;
   assign duration = 33'(cfg.end_time) - 33'(cfg.start_time);
   assign rsp_position = $signed(position);

   ctp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_sample_time (req_sample_time),
      .item            (front_item),
      .cfg             (cfg)
   );

   ctp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_item (front_item),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   ctp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .duration  (duration[31:0]),
      .out_valid (div_valid),
      .out_cls   (div_cls),
      .out_q     (div_q)
   );

   ctp_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid),
      .in_cls        (div_cls),
      .in_s          (div_q),
      .cfg           (cfg),
      .rsp_valid     (rsp_valid),
      .rsp_position  (position),
      .rsp_saturated (rsp_saturated)
   );

endmodule

[hdl/ctp_checker.sv]
// ----------------------------------------------------------------------------
// ctp_props
// Port-level checks: fixed latency in both directions, clipped values and
// reset behavior.
// ----------------------------------------------------------------------------
module ctp_props (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_position,
   input logic               rsp_saturated
);
   import ctp_pkg::*;

   // an accepted item raises the strobe once it has passed the queue, the divider and the back end
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(CTP_LATENCY + 1) rsp_valid)
      else $error("accepted item produced no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, CTP_LATENCY + 1))
      else $error("result without an accepted item");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_position == 32'sh7FFF_FFFF || rsp_position == 32'sh8000_0000))
      else $error("saturated result not at a range limit");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind cubic_trajectory_point ctp_props u_ctp_props (.*);

[dv/ctp_checker.sv]
// ----------------------------------------------------------------------------
// ctp_checker
// Watches the segment register writes, the sample handshake and the position
// strobe, predicts each position from its own copy of the segment and
// compares it field by field with what the evaluator returns.
// ----------------------------------------------------------------------------
module ctp_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [31:0]            req_sample_time,
   input  logic                          rsp_valid,
   input  logic signed [31:0]            rsp_position,
   input  logic                          rsp_saturated,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ctp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   import ctp_pkg::*;

   typedef struct packed {
      logic signed [31:0] position;
      logic               saturated;
   } point_type;

   cfg_type   seg;
   point_type point_q[$];

   function automatic logic [63:0] round_q31(input logic [63:0] x);
      return (x + 64'h4000_0000) >> 31;
   endfunction

   function automatic longint round_signed(input longint x, input int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic point_type eval_point(input logic signed [31:0] t);
      point_type   r;
      longint      ts, te, span, el, d, p;
      logic [63:0] s, u, s2, h, g0, g1, a, b;
      ts = seg.start_time;
      te = seg.end_time;
      r.saturated = 1'b0;
      if (longint'(t) < ts) begin
         r.position = seg.start_position;
      end else if (longint'(t) > te || te <= ts) begin
         r.position = seg.end_position;
      end else begin
         span = te - ts;
         el   = longint'(t) - ts;
         s    = (64'(el) << 31) / 64'(span);
         if (s > 64'h8000_0000) s = 64'h8000_0000;
         u  = 64'h8000_0000 - s;
         s2 = round_q31(s * s);
         h  = round_q31(s2 * (64'h1_8000_0000 - 2 * s));
         g0 = round_q31(round_q31(s * u) * u);
         g1 = round_q31(s2 * u);
         a  = round_q31(g0 * 64'(span));
         b  = round_q31(g1 * 64'(span));
         d  = longint'(seg.end_position) - longint'(seg.start_position);
         p  = longint'(seg.start_position) + round_signed(d * longint'(h), 31)
              + round_signed(longint'(seg.start_velocity) * longint'(a), FRAC_BITS)
              - round_signed(longint'(seg.end_velocity) * longint'(b), FRAC_BITS);
         if (p > 64'sd2147483647) begin
            p = 64'sd2147483647;
            r.saturated = 1'b1;
         end else if (p < -64'sd2147483648) begin
            p = -64'sd2147483648;
            r.saturated = 1'b1;
         end
         r.position = p[31:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         seg.start_time     <= 32'sd0;
         seg.end_time       <= 32'sd65536;
         seg.start_position <= 32'sd0;
         seg.end_position   <= 32'sd0;
         seg.start_velocity <= 32'sd0;
         seg.end_velocity   <= 32'sd0;
         point_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (point_q.size() == 0) begin
               $error("unexpected position item %0d", rsp_position);
               fail_count++;
            end else begin
               want = point_q.pop_front();
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  fail_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated,
                         rsp_saturated);
                  fail_count++;
               end
            end
         end
         if (start && !busy) point_q.push_back(eval_point(req_sample_time));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_TIME:     seg.start_time     <= csr_data;
               CSR_END_TIME:       seg.end_time       <= csr_data;
               CSR_START_POSITION: seg.start_position <= csr_data;
               CSR_END_POSITION:   seg.end_position   <= csr_data;
               CSR_START_VELOCITY: seg.start_velocity <= csr_data;
               CSR_END_VELOCITY:   seg.end_velocity   <= csr_data;
               default: ;
            endcase
         end
      end
      pending_count = point_q.size();
   end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives segment settings and sample times into the trajectory evaluator,
// with random gaps, and reports the verdict from the checker's fail count.
// ----------------------------------------------------------------------------
module tb_top;
   import ctp_pkg::*;

   // indexes past the last register: writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [31:0]   req_sample_time = '0;
   logic                 rsp_valid;
   logic signed [31:0]   rsp_position;
   logic                 rsp_saturated;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;
   int                   fail_count;
   int                   pending_count;
   logic signed [31:0]   t0, t1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cubic_trajectory_point i_dut (.*);

   ctp_checker i_checker (.*);

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (pending_count != 0) @(negedge clock);
      repeat (CTP_LATENCY + 4) @(negedge clock);
   endtask

   task automatic send_sample(input logic signed [31:0] t);
      int gap;
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_sample_time <= t;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic load_segment(input logic [31:0] st, input logic [31:0] et,
                               input logic [31:0] sp, input logic [31:0] ep,
                               input logic [31:0] sv, input logic [31:0] ev);
      start <= 1'b0;
      settle();
      write_reg(CSR_START_TIME, st);
      write_reg(CSR_END_TIME, et);
      write_reg(CSR_START_POSITION, sp);
      write_reg(CSR_END_POSITION, ep);
      write_reg(CSR_START_VELOCITY, sv);
      write_reg(CSR_END_VELOCITY, ev);
   endtask

   function automatic logic [31:0] rnd_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // reset segment: edges, interior and points outside the span
      send_sample(32'sd0);
      send_sample(32'sd65536);
      send_sample(32'sd32768);
      send_sample(-32'sd1);
      send_sample(32'sd65537);
      send_sample(32'h7fff_ffff);
      send_sample(32'h8000_0000);
      // widest span, extreme velocities: saturates both ways
      load_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h8000_0000);
      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(32'h0000_0000);
      send_sample(32'hc000_0000);
      send_sample(32'h4000_0000);
      load_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h8000_0000, 32'h7fff_ffff);
      send_sample(32'hc000_0000);
      send_sample(32'h4000_0000);
      // degenerate segments: equal times and reversed times
      load_segment(32'sd65536, 32'sd65536, 32'sd100, -32'sd200, 32'sd5, 32'sd7);
      send_sample(32'sd65535);
      send_sample(32'sd65536);
      send_sample(32'sd65537);
      load_segment(32'sd65536, -32'sd65536, 32'sd100, -32'sd200, 32'sd5, 32'sd7);
      send_sample(32'sd0);
      send_sample(32'sd65536);
      // unknown index is ignored
      start <= 1'b0;
      settle();
      write_reg(CSR_SPARE_LO, 32'hffff_ffff);
      write_reg(CSR_SPARE_HI, 32'hffff_ffff);
      send_sample(32'sd70000);
      // random segments, mostly sampled inside the span
      for (int k = 0; k < 60; k++) begin
         t0 = rnd_value();
         t1 = ($urandom_range(0, 5) == 0) ? rnd_value()
              : 32'(longint'(t0) + $urandom_range(1, 1 << 20));
         load_segment(t0, t1, rnd_value(), rnd_value(), rnd_value(), rnd_value());
         for (int n = 0; n < 15; n++) begin
            case ($urandom_range(0, 7))
               0: send_sample($urandom);
               1: send_sample($urandom_range(0, 1) ? t0 : t1);
               default: send_sample(t1 > t0
                  ? 32'(longint'(t0) + {$urandom, $urandom} % (longint'(t1) - t0 + 1))
                  : $urandom);
            endcase
         end
      end
      start <= 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
